>>> src/sspq_pkg.sv
// Shared types and codes for the stable sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package sspq_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} sspq_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} sspq_status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} sspq_ctl_t;

endpackage

`default_nettype wire

>>> src/sspq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward tail or head.
`timescale 1ns / 1ps
`default_nettype none

module sspq_cell import sspq_pkg::*; #(
	parameter int PRIORITY_BITS = 16
) (
	input  wire logic                     clk,
	input  wire sspq_ctl_t                ctl,
	input  wire logic                     occupied,
	input  wire logic                     prev_keep,
	input  wire logic [PRIORITY_BITS-1:0] new_prio,
	input  wire logic [15:0]              new_tag,
	input  wire logic [PRIORITY_BITS-1:0] prev_prio,
	input  wire logic [15:0]              prev_tag,
	input  wire logic [PRIORITY_BITS-1:0] next_prio,
	input  wire logic [15:0]              next_tag,
	output logic                          keep,
	output logic [PRIORITY_BITS-1:0]      prio,
	output logic [15:0]                   tag_out
);

	logic [PRIORITY_BITS-1:0] prio_q;
	logic [15:0]              tag_q;

	assign keep    = occupied && (prio_q >= new_prio);
	assign prio    = prio_q;
	assign tag_out = tag_q;

	always_ff @(posedge clk) begin
		if (ctl.rem) begin
			prio_q <= next_prio;
			tag_q  <= next_tag;
		end else if (ctl.ins && !keep) begin
			if (prev_keep) begin
				prio_q <= new_prio;
				tag_q  <= new_tag;
			end else begin
				prio_q <= prev_prio;
				tag_q  <= prev_tag;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built as a chain of cells.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | op, priority_req, tag
//  out     | output    | out_valid / out_ready  | head_priority, head_tag, count,
//          |           |                        | is_empty, status
//
// One item per cycle while in_ready is high: every cell compares against the new
// priority in parallel and an insert or remove moves each cell at most one place.
// The result is registered and shows in the cycle after the item is accepted.
// in_ready drops only while a result is held and out_ready is low.
// Reset empties the queue and clears out_valid; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stable_sorted_priority_queue import sspq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [15:0] priority_req,
	input  wire logic [15:0] tag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      head_priority,
	output logic [15:0]      head_tag,
	output logic [4:0]       count,
	output logic             is_empty,
	output logic [1:0]       status
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_next;
	logic                     full;
	logic                     empty_now;
	logic                     accept;
	sspq_ctl_t                ctl;
	logic [31:0]              req_ext;
	logic [PRIORITY_BITS-1:0] new_prio;
	logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
	logic [15:0]              cell_tag  [DEPTH];
	logic                     keep      [DEPTH];
	logic [PRIORITY_BITS-1:0] head_prio_next;
	logic [15:0]              head_tag_next;
	logic [31:0]              hp_ext;
	logic [31:0]              cnt_ext;
	logic                     empty_next;
	sspq_status_t             status_next;

	logic                     out_valid_q;
	logic [15:0]              head_priority_q;
	logic [15:0]              head_tag_q;
	logic [4:0]               count_out_q;
	logic                     is_empty_q;
	sspq_status_t             status_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty_now = (count_q == '0);
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign req_ext   = 32'(priority_req);
	assign new_prio  = req_ext[PRIORITY_BITS-1:0];

	assign ctl.ins = accept && (op == OP_INSERT) && !full;
	assign ctl.rem = accept && (op == OP_REMOVE) && !empty_now;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     prev_keep_i;
		logic [PRIORITY_BITS-1:0] prev_prio_i;
		logic [15:0]              prev_tag_i;
		logic [PRIORITY_BITS-1:0] next_prio_i;
		logic [15:0]              next_tag_i;

		if (i == 0) begin : g_first
			assign prev_keep_i = 1'b1;
			assign prev_prio_i = new_prio;
			assign prev_tag_i  = tag;
		end else begin : g_mid
			assign prev_keep_i = keep[i-1];
			assign prev_prio_i = cell_prio[i-1];
			assign prev_tag_i  = cell_tag[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_prio_i = cell_prio[i];
			assign next_tag_i  = cell_tag[i];
		end else begin : g_inner
			assign next_prio_i = cell_prio[i+1];
			assign next_tag_i  = cell_tag[i+1];
		end

		sspq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (count_q > CW'(i)),
			.prev_keep (prev_keep_i),
			.new_prio  (new_prio),
			.new_tag   (tag),
			.prev_prio (prev_prio_i),
			.prev_tag  (prev_tag_i),
			.next_prio (next_prio_i),
			.next_tag  (next_tag_i),
			.keep      (keep[i]),
			.prio      (cell_prio[i]),
			.tag_out   (cell_tag[i])
		);
	end

	always_comb begin
		head_prio_next = cell_prio[0];
		head_tag_next  = cell_tag[0];
		count_next     = count_q;
		if (ctl.rem) begin
			head_prio_next = cell_prio[1];
			head_tag_next  = cell_tag[1];
			count_next     = count_q - CW'(1);
		end else if (ctl.ins) begin
			count_next = count_q + CW'(1);
			if (!keep[0]) begin
				head_prio_next = new_prio;
				head_tag_next  = tag;
			end
		end
	end

	assign empty_next = (count_next == '0);
	assign hp_ext     = 32'(head_prio_next);
	assign cnt_ext    = 32'(count_next);

	always_comb begin
		priority if (op == OP_INSERT && full) begin
			status_next = ST_FULL;
		end else if (op == OP_REMOVE && empty_now) begin
			status_next = ST_EMPTY;
		end else begin
			status_next = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_priority_q <= empty_next ? 16'd0 : hp_ext[15:0];
			head_tag_q      <= empty_next ? 16'd0 : head_tag_next;
			count_out_q     <= cnt_ext[4:0];
			is_empty_q      <= empty_next;
			status_q        <= status_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign head_priority = head_priority_q;
	assign head_tag      = head_tag_q;
	assign count         = count_out_q;
	assign is_empty      = is_empty_q;
	assign status        = status_q;

endmodule

`default_nettype wire

>>> src/sspq_checker.sv
// Port-level checks for the stable sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sspq_checker import sspq_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] head_priority,
	input wire logic [15:0] head_tag,
	input wire logic [4:0]  count,
	input wire logic        is_empty,
	input wire logic [1:0]  status
);

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> head_priority == 16'd0 && head_tag == 16'd0)
		else $error("empty queue reports a nonzero head");

	a_remove_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> is_empty && count == 5'd0)
		else $error("remove on empty with entries held");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count) && $stable(status)
			&& $stable(head_priority) && $stable(head_tag))
		else $error("stalled result changed");

endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (.*);

`default_nettype wire
